>>> hdl/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int DATA_W        = 32;

    // Operation codes carried in the kind field.
    typedef enum logic [3:0] {
        KIND_ADD     = 4'd0,
        KIND_SUB     = 4'd1,
        KIND_MUL     = 4'd2,
        KIND_DIV     = 4'd3,
        KIND_CMP     = 4'd4,
        KIND_MIN     = 4'd5,
        KIND_MAX     = 4'd6,
        KIND_INC     = 4'd7,
        KIND_DEC     = 4'd8,
        KIND_I2F     = 4'd9,
        KIND_F2I     = 4'd10
    } kind_t;

    // Data that rides alongside the divider stages.
    typedef struct packed {
        logic [3:0]          kind;
        logic                lt;
        logic                eq;
        logic                gt;
        logic                neg;
        logic                dz;
        logic [DATA_W-1:0]   simple;
        logic [2*DATA_W-1:0] prod;
    } fpa_side_t;

endpackage

>>> hdl/fpa_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
module fpa_div_pipe
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [DATA_W+FRAC_BITS-1:0]    num,
    input  logic [DATA_W-1:0]              den,
    input  fpa_side_t                      side_in,
    output logic                           out_valid,
    output logic [DATA_W+FRAC_BITS-1:0]    quo,
    output logic [DATA_W-1:0]              rem,
    output logic [DATA_W-1:0]              den_out,
    output fpa_side_t                      side_out
);

    localparam int NW = DATA_W + FRAC_BITS;

    logic            valid_reg [NW+1];
    logic [NW-1:0]   nq_reg    [NW+1];
    logic [DATA_W:0] rem_reg   [NW+1];
    logic [DATA_W-1:0] den_reg [NW+1];
    fpa_side_t       side_reg  [NW+1];

    // Stage zero is the entry point of the pipe.
    always_comb
    begin
        valid_reg[0] = in_valid;
        nq_reg[0]    = num;
        rem_reg[0]   = '0;
        den_reg[0]   = den;
        side_reg[0]  = side_in;
    end

    // Each stage shifts in one numerator bit and does one trial subtract.
    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic [DATA_W:0] trial;
        logic [DATA_W:0] rem_next;
        logic            bit_next;

        always_comb
        begin
            trial    = {rem_reg[i][DATA_W-1:0], nq_reg[i][NW-1]};
            bit_next = (trial >= {1'b0, den_reg[i]});
            rem_next = bit_next ? (trial - {1'b0, den_reg[i]}) : trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[i+1]   <= {nq_reg[i][NW-2:0], bit_next};
                rem_reg[i+1]  <= rem_next;
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[NW];
    assign quo       = nq_reg[NW];
    assign rem       = rem_reg[NW][DATA_W-1:0];
    assign den_out   = den_reg[NW];
    assign side_out  = side_reg[NW];

endmodule

>>> hdl/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point ALU.
//
//  Channel  Signals                                           Direction
//  input    in_valid, in_ready, kind, operand_a, operand_b    into block
//  output   out_valid, out_ready, result, less_than, equal,
//           greater_than, overflow, div_by_zero               out of block
//
// Every beat passes stage A, stage B, the one-bit-per-stage divider pipe and the output
// register; the divider pipe sets most of that depth. A new beat enters every cycle while the output is not stalled.
// Reset clears all stage valid bits; the pipe is empty afterwards.
// When the output beat is held by out_ready low, the whole pipe freezes and
// in_ready drops; nothing is lost or repeated.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         kind,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result,
    output logic               less_than,
    output logic               equal,
    output logic               greater_than,
    output logic               overflow,
    output logic               div_by_zero
);

    localparam int NW = DATA_W + FRAC_BITS;

    logic en;

    // Stage A registers.
    logic              a_valid_reg;
    fpa_side_t         a_side_reg;
    logic [DATA_W-1:0] a_maga_reg;
    logic [DATA_W-1:0] a_magb_reg;
    fpa_side_t         a_side_next;

    // Stage B registers.
    logic              b_valid_reg;
    fpa_side_t         b_side_reg;
    fpa_side_t         b_side_next;
    logic [NW-1:0]     b_num_reg;
    logic [DATA_W-1:0] b_den_reg;

    // Divider pipe outputs.
    logic              d_valid;
    logic [NW-1:0]     d_quo;
    logic [DATA_W-1:0] d_rem;
    logic [DATA_W-1:0] d_den;
    fpa_side_t         d_side;

    // Output stage.
    logic              out_valid_reg;
    logic [DATA_W-1:0] result_reg, result_next;
    logic [2:0]        flags_reg;
    logic              ovf_reg, ovf_next;
    logic              dz_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Stage A: compares, magnitudes and the simple operations.
    always_comb
    begin
        a_side_next        = '0;
        a_side_next.kind   = kind;
        a_side_next.lt     = operand_a < operand_b;
        a_side_next.eq     = operand_a == operand_b;
        a_side_next.gt     = operand_a > operand_b;
        a_side_next.neg    = operand_a[DATA_W-1] != operand_b[DATA_W-1];
        a_side_next.dz     = (kind == KIND_DIV) && (operand_b == '0);
        unique case (kind)
            KIND_ADD: a_side_next.simple = operand_a + operand_b;
            KIND_SUB: a_side_next.simple = operand_a - operand_b;
            KIND_MIN: a_side_next.simple = a_side_next.lt ? operand_a : operand_b;
            KIND_MAX: a_side_next.simple = a_side_next.gt ? operand_a : operand_b;
            KIND_INC: a_side_next.simple = operand_a + 32'sd1;
            KIND_DEC: a_side_next.simple = operand_a - 32'sd1;
            KIND_I2F: a_side_next.simple = operand_a << FRAC_BITS;
            KIND_F2I: a_side_next.simple = operand_a >>> FRAC_BITS;
            default:  a_side_next.simple = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= a_side_next;
            a_maga_reg <= operand_a[DATA_W-1] ? (32'd0 - operand_a) : operand_a;
            a_magb_reg <= operand_b[DATA_W-1] ? (32'd0 - operand_b) : operand_b;
        end
    end

    // Stage B: the side data picks up the full magnitude product.
    always_comb
    begin
        b_side_next      = a_side_reg;
        b_side_next.prod = a_maga_reg * a_magb_reg;
    end

    // Stage B: magnitude product and divider operands.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_side_reg <= b_side_next;
            b_num_reg  <= {a_maga_reg, {FRAC_BITS{1'b0}}};
            b_den_reg  <= a_magb_reg;
        end
    end

    fpa_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid_reg),
        .num       (b_num_reg),
        .den       (b_den_reg),
        .side_in   (b_side_reg),
        .out_valid (d_valid),
        .quo       (d_quo),
        .rem       (d_rem),
        .den_out   (d_den),
        .side_out  (d_side)
    );

    // Final stage: rounding, sign and saturation for multiply and divide.
    logic [2*DATA_W-1:0] mul_q;
    logic [NW:0]         div_q;
    logic [NW:0]         mag_q;
    logic                mul_neg;
    logic                sat_neg;

    always_comb
    begin
        mul_q   = (d_side.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        div_q   = {1'b0, d_quo} + {{NW{1'b0}}, ({d_rem, 1'b0} >= {1'b0, d_den})};
        mul_neg = d_side.neg && (d_side.prod != '0);
        if (d_side.kind == KIND_MUL)
        begin
            mag_q   = mul_q[NW:0];
            sat_neg = mul_neg;
        end
        else
        begin
            mag_q   = div_q;
            sat_neg = d_side.neg;
        end

        ovf_next    = 1'b0;
        result_next = d_side.simple;
        if ((d_side.kind == KIND_MUL || d_side.kind == KIND_DIV) && !d_side.dz)
        begin
            if (d_side.kind == KIND_MUL && mul_q[2*DATA_W-1:NW+1] != '0)
            begin
                ovf_next    = 1'b1;
                result_next = sat_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else if (sat_neg)
            begin
                if (mag_q > (NW+1)'(33'h0_8000_0000))
                begin
                    ovf_next    = 1'b1;
                    result_next = 32'h8000_0000;
                end
                else
                begin
                    result_next = 32'd0 - mag_q[DATA_W-1:0];
                end
            end
            else if (mag_q > (NW+1)'(33'h0_7FFF_FFFF))
            begin
                ovf_next    = 1'b1;
                result_next = 32'h7FFF_FFFF;
            end
            else
            begin
                result_next = mag_q[DATA_W-1:0];
            end
        end
        else if (d_side.dz)
        begin
            result_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            flags_reg  <= {d_side.lt, d_side.eq, d_side.gt};
            ovf_reg    <= ovf_next;
            dz_reg     <= d_side.dz;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result       = result_reg;
    assign less_than    = flags_reg[2];
    assign equal        = flags_reg[1];
    assign greater_than = flags_reg[0];
    assign overflow     = ovf_reg;
    assign div_by_zero  = dz_reg;

endmodule

>>> hdl/fpa_checker.sv
// Port-level checker for the fixed-point ALU and its bind statement.
module fpa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result,
    input logic        less_than,
    input logic        equal,
    input logic        greater_than,
    input logic        overflow,
    input logic        div_by_zero
);

    // A held output beat stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("output beat changed while stalled");

    // Exactly one compare relation holds.
    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({less_than, equal, greater_than}))
        else $error("compare flags not one-hot");

    // Divide by zero forces a zero result with no overflow.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> result == 32'd0 && !overflow)
        else $error("divide by zero result not zero");

    // Saturated values are the range limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> result == 32'h7FFF_FFFF || result == 32'h8000_0000)
        else $error("overflow without saturated result");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result       (result),
    .less_than    (less_than),
    .equal        (equal),
    .greater_than (greater_than),
    .overflow     (overflow),
    .div_by_zero  (div_by_zero)
);

>>> bench/fixed_point_alu_checker.sv
// Checker for the fixed-point ALU: watches both channels, predicts and compares beats.
module fixed_point_alu_checker
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [3:0]         kind,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] result,
    input  logic               less_than,
    input  logic               equal,
    input  logic               greater_than,
    input  logic               overflow,
    input  logic               div_by_zero,
    output int                 error_count,
    output int                 pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] value;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        ovf;
        logic        dz;
    } alu_answer_t;

    alu_answer_t answer_q[$];

    // Apply the sign to a magnitude and clamp it to the 32-bit range.
    function automatic logic [31:0] clamp_signed(input logic [63:0] mag, input logic neg,
                                                 output logic ovf);
        ovf = 1'b0;
        if (neg)
        begin
            if (mag > 64'h8000_0000)
            begin
                ovf = 1'b1;
                return 32'h8000_0000;
            end
            return 32'd0 - mag[31:0];
        end
        if (mag > 64'h7FFF_FFFF)
        begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    // Compute the expected answer for one request.
    function automatic alu_answer_t compute_answer(input logic [3:0] k,
                                                   input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        alu_answer_t ans;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] prod;
        logic [63:0] quo;
        logic        o;
        ans = '0;
        ans.lt = a < b;
        ans.eq = a == b;
        ans.gt = a > b;
        ma = a < 0 ? 64'd0 - 64'(signed'(a)) : 64'(a);
        mb = b < 0 ? 64'd0 - 64'(signed'(b)) : 64'(b);
        o = 1'b0;
        case (k)
            KIND_ADD: ans.value = a + b;
            KIND_SUB: ans.value = a - b;
            KIND_MUL:
            begin
                prod = ma * mb;
                quo = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                ans.value = clamp_signed(quo, ((a < 0) != (b < 0)) && prod != 0, o);
            end
            KIND_DIV:
            begin
                if (b == 0)
                    ans.dz = 1'b1;
                else
                begin
                    quo = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
                    ans.value = clamp_signed(quo, (a < 0) != (b < 0), o);
                end
            end
            KIND_CMP: ans.value = '0;
            KIND_MIN: ans.value = ans.lt ? a : b;
            KIND_MAX: ans.value = ans.gt ? a : b;
            KIND_INC: ans.value = a + 1;
            KIND_DEC: ans.value = a - 1;
            KIND_I2F: ans.value = a <<< FRAC_BITS;
            KIND_F2I: ans.value = a >>> FRAC_BITS;
            default:  ans.value = '0;
        endcase
        ans.ovf = o;
        return ans;
    endfunction

    assign pending_count = answer_q.size();

    // Record requests and compare results as beats cross the channels.
    always @(posedge clk or negedge rst_n)
    begin
        alu_answer_t want;
        alu_answer_t seen;
        if (!rst_n)
        begin
            error_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                answer_q.push_back(compute_answer(kind, operand_a, operand_b));
            if (out_valid && out_ready)
            begin
                seen = {result, less_than, equal, greater_than, overflow, div_by_zero};
                if (answer_q.size() == 0)
                begin
                    if (error_count < 10)
                        $display("MISMATCH: result beat with nothing expected, got %h", seen);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (want !== seen)
                    begin
                        if (error_count < 10)
                            $display("MISMATCH: result exp %h got %h, flags lt/eq/gt/ovf/dz exp %b got %b",
                                     want.value, seen.value,
                                     {want.lt, want.eq, want.gt, want.ovf, want.dz},
                                     {seen.lt, seen.eq, seen.gt, seen.ovf, seen.dz});
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> bench/fixed_point_alu_test.sv
// Top of the fixed-point ALU testbench: clock, reset, stimulus and verdict.
module fixed_point_alu_test
    import fpa_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LATENCY = FRAC + 35;
    localparam int RANDOM_BEATS = 1400;
    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] result;
    logic               less_than;
    logic               equal;
    logic               greater_than;
    logic               overflow;
    logic               div_by_zero;
    int                 error_count;
    int                 pending_count;
    int                 cycle_count;

    fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (.*);

    fixed_point_alu_checker #(.FRAC_BITS(FRAC)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle counter with a hard stop for a hung pipe.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver stalls in runs of random length, with some long open stretches.
    initial
    begin
        int run;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 30);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            if ($urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Pick an operand that often sits on an edge of the range.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'(signed'($urandom_range(0, 1024)) - 512);
            4: return {{16{1'b0}}, 16'($urandom())};
            5: return {{16{1'b1}}, 16'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    // Present one beat and hold it until the block takes it.
    task automatic send_beat(input logic [3:0] k, input logic [31:0] a, input logic [31:0] b);
        in_valid  <= 1'b1;
        kind      <= k;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    // Directed corners, then random bursts.
    initial
    begin
        int burst;
        int sent;
        int wait_cycles;
        in_valid  = 1'b0;
        kind      = '0;
        operand_a = '0;
        operand_b = '0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 16; k++)
            send_beat(4'(k), 32'h0000_0380, 32'hFFFF_FE80);
        send_beat(KIND_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_beat(KIND_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(KIND_MUL, 32'h0000_0080, 32'hFFFF_FF01);
        send_beat(KIND_DIV, 32'h1234_5678, 32'd0);
        send_beat(KIND_DIV, 32'h8000_0000, 32'h0000_0001);
        send_beat(KIND_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_beat(KIND_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        send_beat(KIND_F2I, 32'h8000_0000, 32'h8000_0000);
        send_beat(KIND_DEC, 32'h8000_0000, 32'h7FFF_FFFF);

        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < RANDOM_BEATS; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_beat(4'($urandom_range(11, 15)), pick_operand(), pick_operand());
                else
                    send_beat(4'($urandom_range(0, 10)), pick_operand(), pick_operand());
                sent++;
            end
            pause_sender();
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 100 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (2 * LATENCY) @(posedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
